/* design/drs_pkg.sv */
// ----------------------------------------------------------------------------
// drs_pkg
// shared types and constants of the depth registration scatter block
// ----------------------------------------------------------------------------
package drs_pkg;

    // transaction operations
    localparam logic OP_SCATTER = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_CROP_ORIGIN_X = 3'd2;
    localparam logic [2:0] CFG_CROP_ORIGIN_Y = 3'd3;
    localparam logic [2:0] CFG_FULL_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_MIRROR_ENABLE = 3'd5;
    localparam logic [2:0] CFG_MAX_DEPTH     = 3'd6;

    // register reset values
    localparam logic [9:0]  FRAME_WIDTH_RST  = 10'd640;
    localparam logic [8:0]  FRAME_HEIGHT_RST = 9'd480;
    localparam logic [9:0]  FULL_WIDTH_RST   = 10'd640;
    localparam logic [15:0] MAX_DEPTH_RST    = 16'd10000;

    // mirrored column is full_width - x - 2
    localparam logic [12:0] MIRROR_OFFSET = 13'd2;

    // widths of the fixed datapath
    localparam int COORD_W = 13;  // signed working width of x and y
    localparam int BASE_W  = 20;  // linear pixel index before the store bound

    typedef logic [15:0] depth_t;
    typedef logic [BASE_W-1:0] base_t;

endpackage

/* design/drs_ram.sv */
// ----------------------------------------------------------------------------
// drs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/depth_registration_scatter.sv */
// ----------------------------------------------------------------------------
// depth_registration_scatter
// nearest-wins z-buffer scatter of depth points into a frame store with
// read-and-clear readout
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ------------------------------------
//  item      item_valid / item_stall    operation, depth_value, mapped_x,
//                                       mapped_y, read_index
//  result    result_valid / result_stall pixel_depth
//  cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  a scatter transaction (coordinate step, address multiply, then a
//  read-modify-write of two store words through the single write port) ends
//  before the next is taken; a point outside the frame ends at the coordinate
//  step; a read transaction: store read, then clear and load result
//  after reset a clearing pass writes zero to all STORE_DEPTH words, one per
//  cycle, and no item is taken during it; cfg writes are taken at any time
//  a stalled result holds the block only when a further read has to deliver
//
module depth_registration_scatter
    import drs_pkg::*;
#(
    parameter int STORE_DEPTH = 307200
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [15:0] depth_value,
    input  logic [10:0] mapped_x,
    input  logic [10:0] mapped_y,
    input  logic [18:0] read_index,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] pixel_depth,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_COORD = 4'd2;
    localparam logic [3:0] S_ADDR  = 4'd3;
    localparam logic [3:0] S_RD_A  = 4'd4;
    localparam logic [3:0] S_WR_A  = 4'd5;
    localparam logic [3:0] S_WR_B  = 4'd6;
    localparam logic [3:0] S_RD_R  = 4'd7;
    localparam logic [3:0] S_WR_R  = 4'd8;

    // configuration registers
    logic [9:0]  frame_width_reg;
    logic [8:0]  frame_height_reg;
    logic [9:0]  crop_x_reg;
    logic [8:0]  crop_y_reg;
    logic [9:0]  full_width_reg;
    logic        mirror_reg;
    depth_t      max_depth_reg;

    // control
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              result_valid_reg, result_valid_next;

    // captured transaction and datapath
    logic        op_reg;
    depth_t      depth_in_reg;
    logic [10:0] mx_reg;
    logic [10:0] my_reg;
    logic [18:0] ridx_reg;
    logic [9:0]  x_reg, x_next;
    logic [8:0]  y_reg, y_next;
    depth_t      d_reg, d_next;
    base_t       base_reg, base_next;
    logic        ok_a_reg, ok_a_next;
    logic        ok_b_reg, ok_b_next;
    depth_t      pixel_depth_reg, pixel_depth_next;

    // store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    depth_t            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    depth_t            ram_rdata;

    // coordinate step
    logic [COORD_W-1:0] mx_s, my_s, col_s, x_s, y_s;
    logic               hit;
    logic [18:0]        prod;
    base_t              base_inc;
    logic               z_win;
    logic               rd_ok;
    logic               accept;
    logic               result_free;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign pixel_depth  = pixel_depth_reg;
    assign result_free  = !result_valid_reg || !result_stall;

    // signed coordinates, mirror then crop
    assign mx_s  = {{2{mx_reg[10]}}, mx_reg};
    assign my_s  = {{2{my_reg[10]}}, my_reg};
    assign col_s = mirror_reg ? ({3'b000, full_width_reg} - mx_s - MIRROR_OFFSET) : mx_s;
    assign x_s   = col_s - {3'b000, crop_x_reg};
    assign y_s   = my_s - {4'b0000, crop_y_reg};
    // x + 1 < frame_width also rejects frame widths of zero and one
    assign hit   = !x_s[COORD_W-1] && !y_s[COORD_W-1]
                 && (({1'b0, x_s[COORD_W-2:0]} + 13'd1) < {3'b000, frame_width_reg})
                 && (x_s[COORD_W-2:0] < {2'b00, frame_width_reg})
                 && (y_s[COORD_W-2:0] < {3'b000, frame_height_reg});

    assign prod     = 19'(y_reg) * 19'(frame_width_reg);
    assign base_inc = base_reg + base_t'(1);

    // empty pixel or a farther depth loses to the new one
    assign z_win = (ram_rdata == '0) || (ram_rdata > d_reg);
    assign rd_ok = 32'(ridx_reg) < 32'(STORE_DEPTH);

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        result_valid_next = result_valid_reg;
        pixel_depth_next  = pixel_depth_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        d_next            = d_reg;
        base_next         = base_reg;
        ok_a_next         = ok_a_reg;
        ok_b_next         = ok_b_reg;
        ram_we            = 1'b0;
        ram_waddr         = ADDR_W'(base_reg);
        ram_wdata         = d_reg;
        ram_re            = 1'b0;
        ram_raddr         = ADDR_W'(base_reg);

        // result register drains independently of the sequencer
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (operation == OP_READ) ? S_RD_R : S_COORD;
                end
            end
            S_COORD:
            begin
                x_next     = x_s[9:0];
                y_next     = y_s[8:0];
                d_next     = (depth_in_reg < max_depth_reg) ? depth_in_reg : '0;
                state_next = hit ? S_ADDR : S_IDLE;
            end
            S_ADDR:
            begin
                base_next  = base_t'(prod) + base_t'(x_reg);
                ok_a_next  = 32'(base_t'(prod) + base_t'(x_reg)) < 32'(STORE_DEPTH);
                ok_b_next  = 32'(base_t'(prod) + base_t'(x_reg) + base_t'(1))
                           < 32'(STORE_DEPTH);
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(base_reg);
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                ram_we     = ok_a_reg && z_win;
                ram_waddr  = ADDR_W'(base_reg);
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(base_inc);
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                ram_we     = ok_b_reg && z_win;
                ram_waddr  = ADDR_W'(base_inc);
                state_next = S_IDLE;
            end
            S_RD_R:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(ridx_reg);
                state_next = S_WR_R;
            end
            S_WR_R:
            begin
                // read data holds while the result register is still full
                ram_waddr = ADDR_W'(ridx_reg);
                ram_wdata = '0;
                if (result_free)
                begin
                    ram_we            = rd_ok;
                    result_valid_next = 1'b1;
                    pixel_depth_next  = rd_ok ? ram_rdata : '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            crop_x_reg       <= '0;
            crop_y_reg       <= '0;
            full_width_reg   <= FULL_WIDTH_RST;
            mirror_reg       <= 1'b0;
            max_depth_reg    <= MAX_DEPTH_RST;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:   frame_width_reg  <= cfg_data[9:0];
                    CFG_FRAME_HEIGHT:  frame_height_reg <= cfg_data[8:0];
                    CFG_CROP_ORIGIN_X: crop_x_reg       <= cfg_data[9:0];
                    CFG_CROP_ORIGIN_Y: crop_y_reg       <= cfg_data[8:0];
                    CFG_FULL_WIDTH:    full_width_reg   <= cfg_data[9:0];
                    CFG_MIRROR_ENABLE: mirror_reg       <= cfg_data[0];
                    CFG_MAX_DEPTH:     max_depth_reg    <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= operation;
            depth_in_reg <= depth_value;
            mx_reg       <= mapped_x;
            my_reg       <= mapped_y;
            ridx_reg     <= read_index;
        end
        x_reg           <= x_next;
        y_reg           <= y_next;
        d_reg           <= d_next;
        base_reg        <= base_next;
        ok_a_reg        <= ok_a_next;
        ok_b_reg        <= ok_b_next;
        pixel_depth_reg <= pixel_depth_next;
    end

    drs_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // no write ever lands on the word being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store write and read collide on one word");

    // results only come out of the read-and-clear step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_WR_R))
        else $error("result raised outside the read step");

    // a read transaction goes straight to the store read
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_READ) |=> (state_reg == S_RD_R))
        else $error("read transaction not sequenced");

    // only a scatter transaction ever reaches the coordinate step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COORD) |-> (op_reg == OP_SCATTER))
        else $error("read transaction in scatter path");

endmodule
